@@ design/scti_pkg.sv @@
package scti_pkg;

    // Table geometry and number format
    localparam int TABLE_ENTRIES   = 1801;
    localparam int STEPS_PER_ENTRY = 10;
    localparam int FRAC_BITS       = 16;

    // Angles in centidegrees
    localparam int FULL_TURN    = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;
    localparam int EIGHTH_TURN  = 4500;

    // Field widths
    localparam int ANG_W = 21;
    localparam int VAL_W = FRAC_BITS + 2;

    // Angle reduction: a multiple of a full turn makes the angle non-negative
    localparam int ANG_BIAS  = ((2**(ANG_W-1) + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
    localparam int U_W       = $clog2(2**(ANG_W-1) + QUARTER_TURN + ANG_BIAS);
    localparam int MOD_RECIP = (2**U_W) / FULL_TURN;
    localparam int MR_W      = $clog2(MOD_RECIP + 1);
    localparam int M_W       = $clog2(FULL_TURN);
    localparam int D_W       = $clog2(HALF_TURN + 1);

    // Split of the folded angle into table index and step remainder
    localparam int DIV_RECIP  = (2**D_W) / STEPS_PER_ENTRY;
    localparam int DR_W       = $clog2(DIV_RECIP + 1);
    localparam int R_W        = $clog2(STEPS_PER_ENTRY + 1);
    localparam int ADDR_W     = $clog2(TABLE_ENTRIES);
    localparam int LAST_ENTRY = TABLE_ENTRIES - 1;

    // Interpolation arithmetic
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + R_W + 1;
    localparam int NU_W   = PROD_W + R_W + 2;
    localparam logic [NU_W-1:0] RND_DIV   = NU_W'(2 * STEPS_PER_ENTRY);
    localparam logic [NU_W-1:0] RND_BIAS  = RND_DIV << PROD_W;
    localparam logic [NU_W-1:0] RND_RECIP =
        NU_W'((64'd1 << NU_W) / (2 * STEPS_PER_ENTRY));

    // Fixed point constants for building the table
    localparam logic [63:0] ONE_Q62      = 64'd1 << 62;
    localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] CDEG_Q62     = PI_Q62 / 64'd18000;
    localparam int          SERIES_TERMS = 12;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [VAL_W-1:0] t_rom_tbl [TABLE_ENTRIES];

    // Index transfer from the reduction pipe to the table
    typedef struct packed {
        logic             valid;
        logic             is_sine;
        logic [D_W-1:0]   lo;
        logic [R_W-1:0]   rem;
    } t_idx;

    // Table read results toward the interpolator
    typedef struct packed {
        logic             valid;
        logic             is_sine;
        logic [R_W-1:0]   rem;
        t_val             lo_val;
        t_val             hi_val;
    } t_rom_rd;

    // Q62 multiply, product shifted back by 62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned 64-bit quotient by shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series for sine or cosine of c centidegrees, c up to an eighth turn
    function automatic logic [63:0] series_q62(input int unsigned c, input logic want_sin);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        int          k;
        x    = 64'(c) * CDEG_Q62;
        x2   = mul_q62(x, x);
        term = want_sin ? x : ONE_Q62;
        sum  = term;
        for (k = 1; k <= SERIES_TERMS; k++) begin
            dv   = want_sin ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = udiv64(mul_q62(term, x2), dv);
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Cosine of e centidegrees, rounded half away from zero
    function automatic t_val cos_entry(input int unsigned e);
        int unsigned t;
        logic        neg;
        logic [63:0] mag;
        t_val        v;
        t   = e;
        while (t >= FULL_TURN) begin
            t = t - FULL_TURN;
        end
        neg = 1'b0;
        if (t > HALF_TURN) begin
            t = FULL_TURN - t;
        end
        if (t > QUARTER_TURN) begin
            neg = 1'b1;
            t   = HALF_TURN - t;
        end
        if (t > EIGHTH_TURN) begin
            mag = series_q62(QUARTER_TURN - t, 1'b1);
        end else begin
            mag = series_q62(t, 1'b0);
        end
        mag = (mag + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
        v   = t_val'(mag[VAL_W-1:0]);
        return neg ? -v : v;
    endfunction

    // Cosine table, one entry every STEPS_PER_ENTRY centidegrees
    function automatic t_rom_tbl build_rom();
        t_rom_tbl tbl;
        int       i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            tbl[i] = cos_entry(i * STEPS_PER_ENTRY);
        end
        return tbl;
    endfunction

endpackage

@@ design/sine_cosine_table_interp_unit.sv @@
// Sine/cosine by cosine table lookup with linear interpolation, Q1.16 result.
// o_valid follows a taken start through the reduction pipe, the ROM read register and the interpolation pipe.
// Throughput: one angle per cycle; busy is always low, the pipeline never stalls.
// The table is a two-port ROM with registered read data; results cannot be held off.
// Reset (synchronous, active low) clears all valid flags; items in flight are dropped.
module sine_cosine_table_interp_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic signed [scti_pkg::ANG_W-1:0] i_angle_centideg,
    output logic signed [scti_pkg::VAL_W-1:0] o_trig_value,
    output logic                              o_valid
);
    import scti_pkg::*;

    t_idx    w_idx;
    t_rom_rd w_rd;
    logic    w_take;

    // A transfer is taken on every start
    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    scti_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take),
        .i_mode  (i_mode),
        .i_angle (i_angle_centideg),
        .o_idx   (w_idx)
    );

    scti_rom u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (w_idx),
        .o_rd    (w_rd)
    );

    scti_interp u_interp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (w_rd),
        .o_valid      (o_valid),
        .o_trig_value (o_trig_value)
    );

endmodule

@@ design/scti_reduce.sv @@
module scti_reduce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_mode,
    input  logic signed [scti_pkg::ANG_W-1:0] i_angle,
    output scti_pkg::t_idx                    o_idx
);
    import scti_pkg::*;

    logic                   r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic                   r_s1_sin, r_s2_sin, r_s3_sin, r_s4_sin, r_s5_sin, r_s6_sin;
    logic [U_W-1:0]         r_s1_u, r_s2_u;
    logic [U_W+MR_W-1:0]    r_s2_prod;
    logic [M_W-1:0]         r_s3_m;
    logic [D_W-1:0]         r_s4_d, r_s5_d;
    logic [D_W+DR_W-1:0]    r_s5_prod;
    logic [D_W-1:0]         r_s6_lo;
    logic [R_W-1:0]         r_s6_rem;

    logic [U_W-1:0]         n_s1_u;
    logic [MR_W-1:0]        q3;
    logic [U_W-1:0]         rem3;
    logic [M_W-1:0]         n_s3_m;
    logic [D_W-1:0]         n_s4_d;
    logic [DR_W-1:0]        lo6;
    logic [D_W-1:0]         rem6;
    logic [D_W-1:0]         n_s6_lo;
    logic [R_W-1:0]         n_s6_rem;

    // Sine shift by a quarter turn, then bias to a non-negative value
    always_comb begin
        n_s1_u = U_W'(i_angle) + U_W'(ANG_BIAS) + (i_mode ? U_W'(0) : U_W'(QUARTER_TURN));
    end

    // Modulo a full turn: estimated quotient, one correction step
    always_comb begin
        q3   = r_s2_prod[U_W+MR_W-1:U_W];
        rem3 = r_s2_u - U_W'(q3 * FULL_TURN);
        if (rem3 >= U_W'(FULL_TURN)) begin
            n_s3_m = M_W'(rem3 - U_W'(FULL_TURN));
        end else begin
            n_s3_m = M_W'(rem3);
        end
    end

    // Fold the upper half turn
    always_comb begin
        if (r_s3_m >= M_W'(HALF_TURN)) begin
            n_s4_d = D_W'(M_W'(FULL_TURN) - r_s3_m);
        end else begin
            n_s4_d = D_W'(r_s3_m);
        end
    end

    // Table index and step remainder, one correction step
    always_comb begin
        lo6  = r_s5_prod[D_W+DR_W-1:D_W];
        rem6 = r_s5_d - D_W'(lo6 * STEPS_PER_ENTRY);
        if (rem6 >= D_W'(STEPS_PER_ENTRY)) begin
            n_s6_lo  = D_W'(lo6) + D_W'(1);
            n_s6_rem = R_W'(rem6 - D_W'(STEPS_PER_ENTRY));
        end else begin
            n_s6_lo  = D_W'(lo6);
            n_s6_rem = R_W'(rem6);
        end
    end

    // Valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    // Data pipe
    always_ff @(posedge i_clk) begin
        r_s1_sin  <= ~i_mode;
        r_s1_u    <= n_s1_u;
        r_s2_sin  <= r_s1_sin;
        r_s2_u    <= r_s1_u;
        r_s2_prod <= (U_W+MR_W)'(r_s1_u) * (U_W+MR_W)'(MOD_RECIP);
        r_s3_sin  <= r_s2_sin;
        r_s3_m    <= n_s3_m;
        r_s4_sin  <= r_s3_sin;
        r_s4_d    <= n_s4_d;
        r_s5_sin  <= r_s4_sin;
        r_s5_d    <= r_s4_d;
        r_s5_prod <= (D_W+DR_W)'(r_s4_d) * (D_W+DR_W)'(DIV_RECIP);
        r_s6_sin  <= r_s5_sin;
        r_s6_lo   <= n_s6_lo;
        r_s6_rem  <= n_s6_rem;
    end

    always_comb begin
        o_idx.valid   = r_s6_vld;
        o_idx.is_sine = r_s6_sin;
        o_idx.lo      = r_s6_lo;
        o_idx.rem     = r_s6_rem;
    end

endmodule

@@ design/scti_rom.sv @@
module scti_rom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scti_pkg::t_idx    i_idx,
    output scti_pkg::t_rom_rd o_rd
);
    import scti_pkg::*;

    localparam t_rom_tbl ROM = build_rom();

    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [D_W:0]      hi_full;

    logic              r_vld;
    logic              r_sin;
    logic [R_W-1:0]    r_rem;
    t_val              r_lo_val;
    t_val              r_hi_val;

    // Clamp both read addresses at the last entry
    always_comb begin
        hi_full = (D_W+1)'(i_idx.lo) + (D_W+1)'(1);
        if (i_idx.lo > D_W'(LAST_ENTRY)) begin
            lo_addr = ADDR_W'(LAST_ENTRY);
        end else begin
            lo_addr = ADDR_W'(i_idx.lo);
        end
        if (hi_full > (D_W+1)'(LAST_ENTRY)) begin
            hi_addr = ADDR_W'(LAST_ENTRY);
        end else begin
            hi_addr = ADDR_W'(hi_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_idx.valid;
        end
    end

    // Two read ports, registered data
    always_ff @(posedge i_clk) begin
        r_lo_val <= ROM[lo_addr];
        r_hi_val <= ROM[hi_addr];
        r_sin    <= i_idx.is_sine;
        r_rem    <= i_idx.rem;
    end

    always_comb begin
        o_rd.valid   = r_vld;
        o_rd.is_sine = r_sin;
        o_rd.rem     = r_rem;
        o_rd.lo_val  = r_lo_val;
        o_rd.hi_val  = r_hi_val;
    end

endmodule

@@ design/scti_interp.sv @@
module scti_interp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scti_pkg::t_rom_rd                 i_rd,
    output logic                              o_valid,
    output logic signed [scti_pkg::VAL_W-1:0] o_trig_value
);
    import scti_pkg::*;

    logic                     r_s8_vld, r_s9_vld, r_s10_vld, r_s11_vld, r_valid;
    t_val                     r_s8_vl, r_s9_vl, r_s10_vl, r_s11_vl;
    logic signed [DIFF_W-1:0] r_s8_diff;
    logic [R_W-1:0]           r_s8_rem;
    logic signed [PROD_W-1:0] r_s9_prod;
    logic [NU_W-1:0]          r_s10_nu, r_s11_nu;
    logic [2*NU_W-1:0]        r_s11_prod;
    t_val                     r_trig;

    t_val                     n_vl;
    t_val                     n_vh;
    logic signed [DIFF_W-1:0] n_s8_diff;
    logic signed [PROD_W-1:0] n_s9_prod;
    logic [NU_W-1:0]          n_s10_nu;
    logic [NU_W-1:0]          q12;
    logic [NU_W-1:0]          rem12;
    logic [NU_W-1:0]          q12_fix;
    t_val                     n_trig;

    // Sine reads the cosine table negated
    always_comb begin
        n_vl      = i_rd.is_sine ? -i_rd.lo_val : i_rd.lo_val;
        n_vh      = i_rd.is_sine ? -i_rd.hi_val : i_rd.hi_val;
        n_s8_diff = DIFF_W'(n_vh) - DIFF_W'(n_vl);
    end

    // Slope times step remainder
    always_comb begin
        n_s9_prod = PROD_W'(r_s8_diff) * $signed(PROD_W'(r_s8_rem));
    end

    // 2*p + S, biased so the floor division works on an unsigned value
    always_comb begin
        n_s10_nu = (NU_W'(r_s9_prod) << 1) + NU_W'(STEPS_PER_ENTRY) + RND_BIAS;
    end

    // Quotient by 2*S with one correction; the bias drops out mod 2^VAL_W
    always_comb begin
        q12   = r_s11_prod[2*NU_W-1:NU_W];
        rem12 = r_s11_nu - NU_W'(q12 * RND_DIV);
        if (rem12 >= RND_DIV) begin
            q12_fix = q12 + NU_W'(1);
        end else begin
            q12_fix = q12;
        end
        n_trig = r_s11_vl + t_val'(q12_fix[VAL_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_s8_vld  <= i_rd.valid;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_valid   <= r_s11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_vl    <= n_vl;
        r_s8_diff  <= n_s8_diff;
        r_s8_rem   <= i_rd.rem;
        r_s9_vl    <= r_s8_vl;
        r_s9_prod  <= n_s9_prod;
        r_s10_vl   <= r_s9_vl;
        r_s10_nu   <= n_s10_nu;
        r_s11_vl   <= r_s10_vl;
        r_s11_nu   <= r_s10_nu;
        r_s11_prod <= (2*NU_W)'(r_s10_nu) * (2*NU_W)'(RND_RECIP);
        r_trig     <= n_trig;
    end

    assign o_valid      = r_valid;
    assign o_trig_value = r_trig;

endmodule

@@ tb/sine_cosine_table_interp_unit_tb.sv @@
module sine_cosine_table_interp_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scti_pkg::*;

    typedef enum logic {
        MODE_SINE   = 1'b0,
        MODE_COSINE = 1'b1
    } t_trig_mode;

    typedef struct {
        t_trig_mode                    mode;
        logic signed [ANG_W-1:0]       angle;
        logic signed [VAL_W-1:0]       value;
    } t_trig_expect;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int PIPE_SLACK   = 30;
    localparam int CYCLE_LIMIT  = 100000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_mode;
    logic signed [ANG_W-1:0]    i_angle_centideg;
    logic signed [VAL_W-1:0]    o_trig_value;
    logic                       o_valid;

    logic signed [VAL_W-1:0]    cos_table [TABLE_ENTRIES];
    t_trig_expect               pending_trig_q[$];
    int                         err_count;
    int                         cycle_count;
    int                         send_idle_pct;

    sine_cosine_table_interp_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_angle_centideg (i_angle_centideg),
        .o_trig_value     (o_trig_value),
        .o_valid          (o_valid)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Fixed point Q62 product, kept to 64 bits
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[125:62];
    endfunction

    // Taylor series for sin or cos of c centidegrees (c up to 45 deg), Q62
    function automatic logic [63:0] taylor_q62(input int unsigned c, input bit odd_series);
        logic [63:0] x;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] div;
        int          k;
        x    = {32'd0, c} * CDEG_Q62;
        x_sq = q62_product(x, x);
        term = odd_series ? x : ONE_Q62;
        acc  = term;
        for (k = 1; k <= SERIES_TERMS; k++) begin
            div  = odd_series ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = q62_product(term, x_sq) / div;
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    // Cosine of e centidegrees at FRAC_BITS, halves rounded away from zero
    function automatic logic signed [VAL_W-1:0] cos_fixed(input int unsigned e);
        int unsigned             ang;
        bit                      negate;
        logic [63:0]             mag;
        logic signed [VAL_W-1:0] v;
        ang    = e % FULL_TURN;
        negate = 1'b0;
        if (ang > HALF_TURN) ang = FULL_TURN - ang;
        if (ang > QUARTER_TURN) begin
            negate = 1'b1;
            ang    = HALF_TURN - ang;
        end
        if (ang > EIGHTH_TURN) begin
            mag = taylor_q62(QUARTER_TURN - ang, 1'b1);
        end else begin
            mag = taylor_q62(ang, 1'b0);
        end
        mag = (mag + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
        v   = VAL_W'(mag);
        return negate ? -v : v;
    endfunction

    // Interpolated sine or cosine, as the block should produce it
    function automatic logic signed [VAL_W-1:0] predict_trig(
        input t_trig_mode m, input logic signed [ANG_W-1:0] angle);
        int     a;
        int     red;
        int     fold;
        int     lo_idx;
        int     hi_idx;
        int     step_rem;
        longint v_lo;
        longint v_hi;
        longint num;
        longint den;
        longint q;
        a = int'(angle);
        if (m == MODE_SINE) a += QUARTER_TURN;
        red = a % FULL_TURN;
        if (red < 0) red += FULL_TURN;
        fold     = (red >= HALF_TURN) ? FULL_TURN - red : red;
        lo_idx   = fold / STEPS_PER_ENTRY;
        step_rem = fold - lo_idx * STEPS_PER_ENTRY;
        hi_idx   = lo_idx + 1;
        if (lo_idx > LAST_ENTRY) lo_idx = LAST_ENTRY;
        if (hi_idx > LAST_ENTRY) hi_idx = LAST_ENTRY;
        v_lo = longint'(cos_table[lo_idx]);
        v_hi = longint'(cos_table[hi_idx]);
        if (m == MODE_SINE) begin
            v_lo = -v_lo;
            v_hi = -v_hi;
        end
        // round to nearest, ties toward plus infinity
        den = 2 * STEPS_PER_ENTRY;
        num = (v_hi - v_lo) * step_rem * 2 + STEPS_PER_ENTRY;
        q   = (num >= 0) ? num / den : -((-num + den - 1) / den);
        return VAL_W'(v_lo + q);
    endfunction

    // One transfer in; the sender may idle before it
    task automatic send_angle(input t_trig_mode m, input int angle);
        t_trig_expect exp_item;
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start            <= 1'b1;
        i_mode           <= m;
        i_angle_centideg <= ANG_W'(angle);
        do @(posedge i_clk); while (busy);
        exp_item.mode  = m;
        exp_item.angle = ANG_W'(angle);
        exp_item.value = predict_trig(m, ANG_W'(angle));
        pending_trig_q.push_back(exp_item);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_trig_q.size() != 0) @(posedge i_clk);
    endtask

    // Random angle: full range, near quadrant boundaries, or within one turn
    function automatic int random_angle();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0, 1: begin
                return int'($signed(ANG_W'($urandom)));
            end
            2: begin
                return ($signed($urandom_range(0, 232)) - 116) * QUARTER_TURN
                       + $signed($urandom_range(0, 24)) - 12;
            end
            default: begin
                return int'($urandom_range(0, FULL_TURN));
            end
        endcase
    endfunction

    // Largest and smallest angles, and zero
    task automatic test_field_extremes();
        send_angle(MODE_SINE,   -(2 ** (ANG_W - 1)));
        send_angle(MODE_COSINE, -(2 ** (ANG_W - 1)));
        send_angle(MODE_SINE,   2 ** (ANG_W - 1) - 1);
        send_angle(MODE_COSINE, 2 ** (ANG_W - 1) - 1);
        send_angle(MODE_SINE,   0);
        send_angle(MODE_COSINE, 0);
    endtask

    // Quadrant boundaries and negative angles
    task automatic test_quadrant_boundaries();
        send_angle(MODE_COSINE, QUARTER_TURN);
        send_angle(MODE_COSINE, HALF_TURN);
        send_angle(MODE_COSINE, 3 * QUARTER_TURN);
        send_angle(MODE_COSINE, -QUARTER_TURN);
        send_angle(MODE_SINE,   QUARTER_TURN);
        send_angle(MODE_SINE,   -QUARTER_TURN);
        send_angle(MODE_SINE,   3 * QUARTER_TURN);
        send_angle(MODE_COSINE, -1);
        send_angle(MODE_SINE,   -(FULL_TURN - 1));
    endtask

    // Last table entry, and interpolation ties
    task automatic test_table_end_and_ties();
        send_angle(MODE_COSINE, HALF_TURN - STEPS_PER_ENTRY / 2);
        send_angle(MODE_COSINE, HALF_TURN + STEPS_PER_ENTRY / 2);
        send_angle(MODE_SINE,   QUARTER_TURN - STEPS_PER_ENTRY / 2);
        send_angle(MODE_COSINE, STEPS_PER_ENTRY / 2);
        send_angle(MODE_COSINE, 3 * STEPS_PER_ENTRY / 2);
    endtask

    // Random angles at the given sender idle rate
    task automatic test_random_angles(input int idle_pct, input int count);
        int n;
        send_idle_pct = idle_pct;
        for (n = 0; n < count; n++) begin
            send_angle(t_trig_mode'($urandom_range(0, 1)), random_angle());
        end
    endtask

    // Sender stops until the pipeline is empty, then resumes
    task automatic test_pause_until_drained();
        int n;
        for (n = 0; n < 8; n++) begin
            send_angle(t_trig_mode'($urandom_range(0, 1)), random_angle());
        end
        wait_drained();
        for (n = 0; n < 8; n++) begin
            send_angle(t_trig_mode'($urandom_range(0, 1)), random_angle());
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_trig_expect exp_item;
        if (i_rst_n && o_valid) begin
            if (pending_trig_q.size() == 0) begin
                $error("unexpected result: trig_value %0d", o_trig_value);
                err_count++;
            end else begin
                exp_item = pending_trig_q.pop_front();
                if (o_trig_value !== exp_item.value) begin
                    $error("trig_value mismatch (mode %0d angle %0d): expected %0d, actual %0d",
                           exp_item.mode, exp_item.angle, exp_item.value, o_trig_value);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int i;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_mode           = 1'b0;
        i_angle_centideg = '0;
        err_count        = 0;
        cycle_count      = 0;
        send_idle_pct    = 0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            cos_table[i] = cos_fixed(i * STEPS_PER_ENTRY);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        test_field_extremes();
        test_quadrant_boundaries();
        test_table_end_and_ties();
        test_pause_until_drained();

        test_random_angles(34, 300);
        test_random_angles(85, 300);
        test_random_angles(0, 300);

        wait_drained();
        repeat (PIPE_SLACK) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sine_cosine_table_interp_unit.f @@
design/scti_pkg.sv
design/scti_reduce.sv
design/scti_rom.sv
design/scti_interp.sv
design/sine_cosine_table_interp_unit.sv
tb/sine_cosine_table_interp_unit_tb.sv
